// ===== rtl/hsv_pkg.sv =====
// Shared types and constants of the HSV to RGB converter.
// Used by every module of the block; depends on nothing else.
package hsv_pkg;

  // Field widths.
  localparam int unsigned HueW  = 16;
  localparam int unsigned ChanW = 8;
  localparam int unsigned SectW = 4;
  localparam int unsigned FracW = 8;

  // Hue circle register: smallest usable circle and reset values.
  localparam logic [HueW-1:0] CircleMin   = 16'd6;
  localparam logic [HueW-1:0] CircleReset = 16'd360;
  localparam logic [HueW-1:0] WidthReset  = 16'd60;

  // Division by six as a multiply by ceil(2^18 / 6) and a right shift.
  // This is exact for every 16-bit dividend.
  localparam logic [16:0]  RecipSix   = 17'd43691;
  localparam int unsigned  RecipShift = 18;

  // Full channel level.
  localparam logic [ChanW-1:0] FullLevel = 8'hFF;

  // Hue sectors; any higher sector uses the red sector mapping.
  localparam logic [SectW-1:0] SectRed     = 4'd0;
  localparam logic [SectW-1:0] SectYellow  = 4'd1;
  localparam logic [SectW-1:0] SectGreen   = 4'd2;
  localparam logic [SectW-1:0] SectCyan    = 4'd3;
  localparam logic [SectW-1:0] SectBlue    = 4'd4;
  localparam logic [SectW-1:0] SectMagenta = 4'd5;

  // Pipeline depth: three divider pipes, three mixing stages.
  localparam int unsigned MixStages    = 3;
  localparam int unsigned PipeStages   = HueW + SectW + FracW + MixStages;
  // Items the block can hold: pipeline plus output register and skid slot.
  localparam int unsigned PipeCapacity = PipeStages + 2;

  // Hue circle settings seen by the datapath.
  typedef struct packed {
    logic [HueW-1:0] circle;  // circle, at least six
    logic [HueW-1:0] width;   // sector width, circle / 6
  } cfg_t;

  // One color result, red in the lowest bits.
  typedef struct packed {
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] red;
  } rgb_t;

endpackage

// ===== rtl/hsv_to_rgb_converter.sv =====
// HSV to RGB converter, top level. It takes one item per clock cycle at any
// hue circle setting while the skid slot is empty, and returns its color with
// 8 bits per channel. Each item passes through three restoring dividers that
// resolve one quotient bit per register stage (16 stages for the hue modulo the
// circle, 4 for the sector and 8 for the offset within the sector), followed by
// three mixing stages and the output register. A skid slot behind the output
// register lets the pipeline take one more item while a result waits. Write the
// hue circle only while no item is in flight; a value below six acts as six.
// Depends on hsv_pkg, hsv_cfg, hsv_div_pipe and hsv_mix.
module hsv_to_rgb_converter import hsv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Hue circle register.
  input  logic            cfg_we_i,
  input  logic [HueW-1:0] cfg_wdata_i,
  // Input items.
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [31:0]     s_axis_tdata,   // hue[15:0], saturation[23:16], brightness[31:24]
  // Result items.
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [23:0]     m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);

  cfg_t cfg;

  logic             en;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] sat, val;

  logic             mod_vld;
  logic [HueW-1:0]  mod_quo, mod_rem;
  logic [15:0]      mod_side;

  logic             sec_vld;
  logic [SectW-1:0] sec_quo;
  logic [HueW-1:0]  sec_rem;
  logic [15:0]      sec_side;

  logic             frc_vld;
  logic [FracW-1:0] frc_quo;
  logic [HueW-1:0]  frc_rem;
  logic [19:0]      frc_side;

  logic             mix_vld;
  rgb_t             mix_rgb;

  logic             out_vld_q, skid_vld_q;
  rgb_t             out_rgb_q, skid_rgb_q;
  logic             push, out_free;

  assign hue = s_axis_tdata[15:0];
  assign sat = s_axis_tdata[23:16];
  assign val = s_axis_tdata[31:24];

  // The whole pipeline moves while the skid slot is empty.
  assign en            = !skid_vld_q;
  assign s_axis_tready = en;

  hsv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Hue modulo the circle.
  hsv_div_pipe #(.Steps(HueW), .Width(HueW), .SideW(16)) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .rem_i     ('0),
    .bits_i    (hue),
    .divisor_i (cfg.circle),
    .side_i    ({sat, val}),
    .valid_o   (mod_vld),
    .quo_o     (mod_quo),
    .rem_o     (mod_rem),
    .side_o    (mod_side)
  );

  // Sector index: the reduced hue over the sector width, below twelve.
  hsv_div_pipe #(.Steps(SectW), .Width(HueW), .SideW(16)) u_sector (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (mod_vld),
    .rem_i     (HueW'(mod_rem[HueW-1:SectW])),
    .bits_i    (mod_rem[SectW-1:0]),
    .divisor_i (cfg.width),
    .side_i    (mod_side),
    .valid_o   (sec_vld),
    .quo_o     (sec_quo),
    .rem_o     (sec_rem),
    .side_o    (sec_side)
  );

  // Offset within the sector scaled to 0..255.
  hsv_div_pipe #(.Steps(FracW), .Width(HueW), .SideW(20)) u_frac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (sec_vld),
    .rem_i     (sec_rem),
    .bits_i    ('0),
    .divisor_i (cfg.width),
    .side_i    ({sec_quo, sec_side}),
    .valid_o   (frc_vld),
    .quo_o     (frc_quo),
    .rem_o     (frc_rem),
    .side_o    (frc_side)
  );

  hsv_mix u_mix (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (frc_vld),
    .frac_i   (frc_quo),
    .sector_i (frc_side[19:16]),
    .sat_i    (frc_side[15:8]),
    .val_i    (frc_side[7:0]),
    .valid_o  (mix_vld),
    .rgb_o    (mix_rgb)
  );

  // Output register with a skid slot for the item in flight when it stalls.
  assign push     = en && mix_vld;
  assign out_free = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (m_axis_tready) begin
        skid_vld_q <= 1'b0;
      end
    end else if (out_free) begin
      out_vld_q <= push;
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (m_axis_tready) begin
        out_rgb_q <= skid_rgb_q;
      end
    end else if (out_free) begin
      out_rgb_q <= mix_rgb;
    end else begin
      skid_rgb_q <= mix_rgb;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_rgb_q;

endmodule

// ===== rtl/hsv_cfg.sv =====
// Hue circle register with the derived sector width.
// Depends on hsv_pkg for the reset values and the divide-by-six constant.
module hsv_cfg import hsv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [HueW-1:0] cfg_wdata_i,
  output cfg_t            cfg_o
);

  logic [HueW-1:0] circle_d, circle_q;
  logic [HueW-1:0] width_d, width_q;
  logic [31:0]     recip_prod;

  // Clamp the circle to at least six and divide it by six.
  always_comb begin
    circle_d   = (cfg_wdata_i < CircleMin) ? CircleMin : cfg_wdata_i;
    recip_prod = 32'(circle_d) * 32'(RecipSix);
    width_d    = HueW'(recip_prod >> RecipShift);
  end

  // Both values are stored on the write itself.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circle_q <= CircleReset;
      width_q  <= WidthReset;
    end else if (cfg_we_i) begin
      circle_q <= circle_d;
      width_q  <= width_d;
    end
  end

  assign cfg_o = '{circle: circle_q, width: width_q};

endmodule

// ===== rtl/hsv_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on hsv_pkg only through the import; sizes come from its parameters.
module hsv_div_pipe import hsv_pkg::*; #(
  parameter int unsigned Steps = 16,
  parameter int unsigned Width = 16,
  parameter int unsigned SideW = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [Width-1:0] rem_i,      // starting remainder, below the divisor
  input  logic [Steps-1:0] bits_i,     // dividend bits shifted in, MSB first
  input  logic [Width-1:0] divisor_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [Steps-1:0] quo_o,
  output logic [Width-1:0] rem_o,
  output logic [SideW-1:0] side_o
);

  // Stage registers.
  logic [Steps-1:0] vld_q;
  logic [Width-1:0] rem_q  [Steps];
  logic [Steps-1:0] bits_q [Steps];
  logic [Steps-1:0] quo_q  [Steps];
  logic [SideW-1:0] side_q [Steps];

  // Inputs of each stage.
  logic             vld_in  [Steps];
  logic [Width-1:0] rem_in  [Steps];
  logic [Steps-1:0] bits_in [Steps];
  logic [Steps-1:0] quo_in  [Steps];
  logic [SideW-1:0] side_in [Steps];

  for (genvar g = 0; g < Steps; g++) begin : g_stage
    logic [Width:0]   shifted;
    logic [Width:0]   trial;
    logic             fits;
    logic [Width-1:0] rem_d;

    // Chain each stage to the one before it.
    if (g == 0) begin : g_first
      assign vld_in[g]  = valid_i;
      assign rem_in[g]  = rem_i;
      assign bits_in[g] = bits_i;
      assign quo_in[g]  = '0;
      assign side_in[g] = side_i;
    end else begin : g_next
      assign vld_in[g]  = vld_q[g-1];
      assign rem_in[g]  = rem_q[g-1];
      assign bits_in[g] = bits_q[g-1];
      assign quo_in[g]  = quo_q[g-1];
      assign side_in[g] = side_q[g-1];
    end

    // Bring down the next dividend bit and subtract the divisor if it fits.
    always_comb begin
      shifted = {rem_in[g], bits_in[g][Steps-1]};
      trial   = shifted - {1'b0, divisor_i};
      fits    = (shifted >= {1'b0, divisor_i});
      rem_d   = fits ? trial[Width-1:0] : shifted[Width-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g] <= 1'b0;
      end else if (en_i) begin
        vld_q[g] <= vld_in[g];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        bits_q[g] <= bits_in[g] << 1;
        quo_q[g]  <= {quo_in[g][Steps-2:0], fits};
        side_q[g] <= side_in[g];
      end
    end
  end

  assign valid_o = vld_q[Steps-1];
  assign quo_o   = quo_q[Steps-1];
  assign rem_o   = rem_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// ===== rtl/hsv_mix.sv =====
// Three-stage color mixer: forms p, q and t and routes them by hue sector.
// Depends on hsv_pkg for widths, sector codes and the rgb_t result type.
module hsv_mix import hsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [FracW-1:0] frac_i,
  input  logic [SectW-1:0] sector_i,
  input  logic [ChanW-1:0] sat_i,
  input  logic [ChanW-1:0] val_i,
  output logic             valid_o,
  output rgb_t             rgb_o
);

  // Stage A: the three first products.
  logic             a_vld_q;
  logic [15:0]      a_p_prod_q, a_sf_prod_q, a_sg_prod_q;
  logic [ChanW-1:0] a_val_q;
  logic [SectW-1:0] a_sector_q;
  logic             a_gray_q;

  // Stage B: p and the products behind q and t.
  logic             b_vld_q;
  logic [ChanW-1:0] b_p_q;
  logic [15:0]      b_q_prod_q, b_t_prod_q;
  logic [ChanW-1:0] b_val_q;
  logic [SectW-1:0] b_sector_q;
  logic             b_gray_q;

  // Stage C: the routed color.
  logic             c_vld_q;
  rgb_t             c_rgb_d, c_rgb_q;

  logic [ChanW-1:0] sf_level, sg_level;
  logic [ChanW-1:0] q_lvl, t_lvl;

  assign sf_level = FullLevel - a_sf_prod_q[15:8];
  assign sg_level = FullLevel - a_sg_prod_q[15:8];
  assign q_lvl    = b_q_prod_q[15:8];
  assign t_lvl    = b_t_prod_q[15:8];

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= valid_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  // Products of stage A and stage B, and the routed color of stage C.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_p_prod_q  <= 16'(FullLevel - sat_i) * 16'(val_i);
      a_sf_prod_q <= 16'(sat_i) * 16'(frac_i);
      a_sg_prod_q <= 16'(sat_i) * 16'(FullLevel - frac_i);
      a_val_q     <= val_i;
      a_sector_q  <= sector_i;
      a_gray_q    <= (sat_i == '0);

      b_p_q       <= a_p_prod_q[15:8];
      b_q_prod_q  <= 16'(sf_level) * 16'(a_val_q);
      b_t_prod_q  <= 16'(sg_level) * 16'(a_val_q);
      b_val_q     <= a_val_q;
      b_sector_q  <= a_sector_q;
      b_gray_q    <= a_gray_q;

      c_rgb_q     <= c_rgb_d;
    end
  end

  // Route p, q, t and the brightness by sector; zero saturation gives gray.
  always_comb begin
    case (b_sector_q)
      SectYellow:  c_rgb_d = '{red: q_lvl,   green: b_val_q, blue: b_p_q};
      SectGreen:   c_rgb_d = '{red: b_p_q,   green: b_val_q, blue: t_lvl};
      SectCyan:    c_rgb_d = '{red: b_p_q,   green: q_lvl,   blue: b_val_q};
      SectBlue:    c_rgb_d = '{red: t_lvl,   green: b_p_q,   blue: b_val_q};
      SectMagenta: c_rgb_d = '{red: b_val_q, green: b_p_q,   blue: q_lvl};
      default:     c_rgb_d = '{red: b_val_q, green: t_lvl,   blue: b_p_q};
    endcase
    if (b_gray_q) begin
      c_rgb_d = '{red: b_val_q, green: b_val_q, blue: b_val_q};
    end
  end

  assign valid_o = c_vld_q;
  assign rgb_o   = c_rgb_q;

endmodule

// ===== rtl/hsv_chk.sv =====
// Port-level checker for the HSV to RGB converter and its bind statement.
// Depends on hsv_pkg for the number of items the block can hold.
module hsv_chk import hsv_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  localparam int unsigned CntW = $clog2(PipeCapacity + 1);

  logic [CntW-1:0] cnt_q;
  logic            in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Count the items accepted and not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_acc && !out_acc) begin
      cnt_q <= cnt_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result item dropped while stalled");

  // A stalled result keeps its color.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  // Every result comes from an accepted item.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("result item without a pending input item");

  // Back-pressure keeps the items in flight within the pipeline's room.
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PipeCapacity))
    else $error("more items in flight than the pipeline holds");

endmodule

bind hsv_to_rgb_converter hsv_chk u_hsv_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/hsv_to_rgb_converter_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of hsv_to_rgb_converter: random and directed pixels
// against an in-bench color predictor, across several hue circle settings.
// Depends on hsv_pkg and the hsv_to_rgb_converter RTL.
module hsv_to_rgb_converter_tb import hsv_pkg::*; ();

  localparam int unsigned NumSectors = 6;
  localparam int unsigned FracScale  = 'h100;
  localparam int unsigned FullMask   = 'hff;
  localparam int unsigned DrainWait  = PipeCapacity + 8;
  localparam int unsigned HoldCycles = 4 * PipeCapacity;
  localparam int unsigned NumPhases  = 10;
  localparam int unsigned PhaseItems = 120;

  // One input pixel, hue in the lowest bits as on s_axis_tdata.
  typedef struct packed {
    logic [ChanW-1:0] brightness;
    logic [ChanW-1:0] saturation;
    logic [HueW-1:0]  hue;
  } hsv_item_t;

  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic [HueW-1:0] cfg_wdata_i   = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [31:0]     s_axis_tdata  = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [23:0]     m_axis_tdata;

  // Bench copy of the hue circle register.
  logic [HueW-1:0] circle_setting = CircleReset;

  hsv_item_t   pixel_queue[$];
  rgb_t        color_expected[$];
  int unsigned mismatch_count  = 0;
  int unsigned tx_idle_pct     = 0;
  int unsigned rx_idle_pct     = 0;
  int unsigned tx_gap          = 0;
  int unsigned rx_gap          = 0;
  int unsigned rx_hold_cnt     = 0;
  bit          rx_hold_pending = 1'b0;
  bit          in_fire         = 1'b0;

  hsv_to_rgb_converter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 50 MHz clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Reset is held low at the start and then released.
  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Eight-bit multiply followed by a shift down by eight.
  function automatic int unsigned scale_level(int unsigned a, int unsigned b);
    return ((a * b) >> 8) & FullMask;
  endfunction

  // Predicts the color of one pixel under a given hue circle setting.
  function automatic rgb_t hsv_to_color(hsv_item_t px, logic [HueW-1:0] circle_reg);
    int unsigned circle, width, h, sector, frac, s, v, p, q, t;
    rgb_t        c;
    s = px.saturation;
    v = px.brightness;
    if (s == 0) begin
      c.red   = px.brightness;
      c.green = px.brightness;
      c.blue  = px.brightness;
      return c;
    end
    // A circle below six behaves as six.
    circle = (circle_reg < NumSectors) ? NumSectors : circle_reg;
    width  = circle / NumSectors;
    h      = px.hue % circle;
    sector = h / width;
    frac   = (((h - width * sector) * FracScale) / width) & FullMask;
    p = scale_level(FullMask - s, v);
    q = scale_level(FullMask - scale_level(s, frac), v);
    t = scale_level(FullMask - scale_level(s, FullMask - frac), v);
    // Sectors past magenta fall back to the red mapping.
    case (sector)
      SectYellow:  begin c.red = 8'(q); c.green = 8'(v); c.blue = 8'(p); end
      SectGreen:   begin c.red = 8'(p); c.green = 8'(v); c.blue = 8'(t); end
      SectCyan:    begin c.red = 8'(p); c.green = 8'(q); c.blue = 8'(v); end
      SectBlue:    begin c.red = 8'(t); c.green = 8'(p); c.blue = 8'(v); end
      SectMagenta: begin c.red = 8'(v); c.green = 8'(p); c.blue = 8'(q); end
      default:     begin c.red = 8'(v); c.green = 8'(t); c.blue = 8'(p); end
    endcase
    return c;
  endfunction

  // Random pixel, biased toward sector edges and the first few turns.
  function automatic hsv_item_t random_pixel(logic [HueW-1:0] circle_reg);
    int unsigned circle, width, span, k;
    hsv_item_t   px;
    circle = (circle_reg < NumSectors) ? NumSectors : circle_reg;
    width  = circle / NumSectors;
    case ($urandom_range(0, 7))
      0, 1: px.hue = HueW'($urandom);
      2, 3: px.hue = HueW'($urandom_range(0, circle - 1));
      4: begin
        k      = $urandom_range(0, NumSectors);
        px.hue = HueW'(k * width + $urandom_range(0, 2) - 1);
      end
      5: begin
        case ($urandom_range(0, 3))
          0:       px.hue = '0;
          1:       px.hue = HueW'(circle - 1);
          2:       px.hue = HueW'(circle);
          default: px.hue = '1;
        endcase
      end
      default: begin
        span   = (3 * circle > 'hffff) ? 'hffff : 3 * circle;
        px.hue = HueW'($urandom_range(0, span));
      end
    endcase
    case ($urandom_range(0, 15))
      0, 1:    px.saturation = '0;
      2, 3:    px.saturation = FullLevel;
      4:       px.saturation = 8'd1;
      default: px.saturation = ChanW'($urandom);
    endcase
    case ($urandom_range(0, 15))
      0:       px.brightness = '0;
      1, 2:    px.brightness = FullLevel;
      default: px.brightness = ChanW'($urandom);
    endcase
    return px;
  endfunction

  task automatic add_pixel(logic [HueW-1:0] hue, logic [ChanW-1:0] sat,
                           logic [ChanW-1:0] val);
    hsv_item_t px;
    px.hue        = hue;
    px.saturation = sat;
    px.brightness = val;
    pixel_queue.push_back(px);
  endtask

  // Waits until every queued pixel is sent and every color has come back.
  task automatic wait_drained();
    while (pixel_queue.size() != 0 || s_axis_tvalid || color_expected.size() != 0)
      @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
  endtask

  // Register write; only called with the pipeline empty.
  task automatic write_circle(logic [HueW-1:0] value);
    wait_drained();
    cfg_wdata_i    = value;
    cfg_we_i       = 1'b1;
    circle_setting = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    @(posedge clk_i);
  endtask

  // Input driver: holds an item until it is taken, idles in short bursts.
  always @(negedge clk_i) begin
    if (s_axis_tvalid && !in_fire) begin
      // Item still waiting for the block.
    end else if (tx_gap > 0) begin
      tx_gap        = tx_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (rst_ni && pixel_queue.size() != 0) begin
      if ($urandom_range(0, 99) < tx_idle_pct) begin
        tx_gap        = $urandom_range(0, 4);
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tdata  <= pixel_queue.pop_front();
        s_axis_tvalid <= 1'b1;
      end
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // Result receiver: random stall bursts, and one long hold-off on request.
  always @(negedge clk_i) begin
    logic ready_next;
    ready_next = 1'b1;
    if (rx_hold_cnt > 0) begin
      rx_hold_cnt = rx_hold_cnt - 1;
      ready_next  = 1'b0;
    end else if (rx_hold_pending) begin
      rx_hold_pending = 1'b0;
      rx_hold_cnt     = HoldCycles - 1;
      ready_next      = 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap     = rx_gap - 1;
      ready_next = 1'b0;
    end else if ($urandom_range(0, 99) < rx_idle_pct) begin
      rx_gap     = $urandom_range(0, 4);
      ready_next = 1'b0;
    end
    m_axis_tready <= ready_next;
  end

  // Monitor: checks each returned color, then predicts each accepted pixel.
  always @(posedge clk_i) begin
    rgb_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (color_expected.size() == 0) begin
        $display("%0t: expected no color, actual r=%0d g=%0d b=%0d", $time,
                 got.red, got.green, got.blue);
        mismatch_count++;
      end else begin
        want = color_expected.pop_front();
        if (got.red !== want.red) begin
          $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
          mismatch_count++;
        end
        if (got.green !== want.green) begin
          $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
          mismatch_count++;
        end
        if (got.blue !== want.blue) begin
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
          mismatch_count++;
        end
      end
    end
    in_fire <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      color_expected.push_back(hsv_to_color(s_axis_tdata, circle_setting));
  end

  // Stimulus: directed pixels first, then one random phase per circle setting.
  initial begin
    logic [HueW-1:0] circle;
    @(posedge rst_ni);
    @(posedge clk_i);
    tx_idle_pct = 20;
    rx_idle_pct = 20;

    // Reset circle: gray levels, hue extremes and the center of each sector.
    add_pixel(16'd0, 8'd0, 8'd0);
    add_pixel(16'hffff, 8'd0, 8'd255);
    add_pixel(16'd0, 8'd255, 8'd255);
    add_pixel(16'd30, 8'd255, 8'd200);
    add_pixel(16'd90, 8'd200, 8'd255);
    add_pixel(16'd150, 8'd200, 8'd255);
    add_pixel(16'd210, 8'd200, 8'd255);
    add_pixel(16'd270, 8'd200, 8'd255);
    add_pixel(16'd330, 8'd200, 8'd255);
    add_pixel(16'd359, 8'd255, 8'd255);
    add_pixel(16'd360, 8'd128, 8'd128);
    add_pixel(16'hffff, 8'd1, 8'd1);
    add_pixel(16'd60, 8'd255, 8'd0);
    add_pixel(16'd119, 8'd255, 8'd255);

    // A circle that is not a multiple of six reaches a seventh sector.
    write_circle(16'd7);
    add_pixel(16'd6, 8'd200, 8'd200);
    add_pixel(16'd13, 8'd255, 8'd255);
    add_pixel(16'd5, 8'd17, 8'd240);

    // A circle below six acts as six.
    write_circle(16'd3);
    add_pixel(16'd5, 8'd255, 8'd255);
    add_pixel(16'd2, 8'd90, 8'd180);

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       circle = CircleReset;
        1:       circle = CircleMin;
        2:       circle = '0;
        3:       circle = '1;
        4:       circle = 16'd7;
        5:       circle = 16'd11;
        6:       circle = 16'd1536;
        7:       circle = HueW'($urandom_range(6, 'hffff));
        8:       circle = HueW'($urandom_range(12, 200));
        default: circle = 16'd359;
      endcase
      write_circle(circle);
      if (p == NumPhases - 1) begin
        // Closing stretch runs without any idling.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = (p % 3 == 0) ? 0 : 25;
        rx_idle_pct = (p % 4 == 1) ? 0 : 30;
      end
      // Stall the output long enough for the block to back up its input.
      if (p == 0)
        rx_hold_pending = 1'b1;
      for (int i = 0; i < PhaseItems; i++)
        pixel_queue.push_back(random_pixel(circle));
    end

    wait_drained();
    if (mismatch_count == 0 && color_expected.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
